// ===== sv/apsa_pkg.sv =====
// Shared types, codes and constants for the pass-one symbol allocator.
package apsa_pkg;

   // Default sizing, handed to the top-level parameters
   localparam int OPCODE_DEPTH_DEFAULT = 32;
   localparam int SYMBOL_DEPTH_DEFAULT = 32;
   localparam int ADDRESS_BITS_DEFAULT = 24;

   // Fixed field widths
   localparam int OPERATION_BITS = 2;
   localparam int TEXT_BITS      = 64;
   localparam int VALUE_BITS     = 24;
   localparam int LENGTH_BITS    = 5;
   localparam int CHAR_BITS      = 8;
   localparam int STATUS_BITS    = 3;
   localparam int OUT_ADDR_BITS  = 24;
   localparam int COUNT_BITS     = 6;

   // Operation codes
   localparam logic [OPERATION_BITS-1:0] OP_LOAD   = 2'd0;
   localparam logic [OPERATION_BITS-1:0] OP_START  = 2'd1;
   localparam logic [OPERATION_BITS-1:0] OP_SOURCE = 2'd2;
   localparam logic [OPERATION_BITS-1:0] OP_END    = 2'd3;

   // Result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_DUP      = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_SYM_FULL = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_HALTED   = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_OP_FULL  = 3'd4;

   // Directive names, first character in the low byte
   localparam logic [TEXT_BITS-1:0] TEXT_WORD = 64'h0000_0000_4452_4F57;
   localparam logic [TEXT_BITS-1:0] TEXT_RESW = 64'h0000_0000_5753_4552;
   localparam logic [TEXT_BITS-1:0] TEXT_RESB = 64'h0000_0000_4253_4552;
   localparam logic [TEXT_BITS-1:0] TEXT_BYTE = 64'h0000_0000_4554_5942;

   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_C = 8'h43;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_C = 8'h63;

   localparam int WORD_BYTES = 3;
   localparam logic [LENGTH_BITS-1:0] BYTE_OVERHEAD = 5'd3;

   // Controller states
   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_SCAN,
      CTL_COMMIT
   } ctl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_item;
      logic scan_start;
      logic scan_run;
      logic commit;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_done;
      logic halted;
      logic out_free;
   } dp_status_type;

endpackage

// ===== sv/assembler_pass1_symbol_allocator.sv =====
// Statements are taken one at a time: accept, a table scan for live source statements,
// then commit into the result register. Both RAMs are scanned in lockstep through their
// single read ports, one entry a cycle, up to N = max(opcodes loaded, labels held when the
// statement has a label). A new statement is accepted only after the previous one has
// committed, and a stalled result holds the commit and so the next accept. Reset
// (synchronous, active high) clears counters, halt, handshake.
module assembler_pass1_symbol_allocator import apsa_pkg::*; #(
   parameter int OPCODE_DEPTH = OPCODE_DEPTH_DEFAULT,
   parameter int SYMBOL_DEPTH = SYMBOL_DEPTH_DEFAULT,
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // Statement transactions in
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [OPERATION_BITS-1:0] req_operation,
   input  logic                      req_label_present,
   input  logic [TEXT_BITS-1:0]      req_label_text,
   input  logic [TEXT_BITS-1:0]      req_mnemonic_text,
   input  logic [VALUE_BITS-1:0]     req_operand_value,
   input  logic [LENGTH_BITS-1:0]    req_operand_length,
   input  logic [CHAR_BITS-1:0]      req_operand_first_char,
   // Result transactions out
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STATUS_BITS-1:0]    rsp_status,
   output logic [OUT_ADDR_BITS-1:0]  rsp_address,
   output logic [OUT_ADDR_BITS-1:0]  rsp_program_length,
   output logic [OUT_ADDR_BITS-1:0]  rsp_object_bytes,
   output logic [COUNT_BITS-1:0]     rsp_symbol_count
);

   // Commands from the controller, status back from the datapath
   dp_cmd_type    cmd;
   dp_status_type dp_status;

   // Controller: accept a transaction, run the scan when a live source
   // statement needs it, then commit once the result register is free.
   apsa_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .status        (dp_status),
      .cmd           (cmd)
   );

   // Datapath: latch the statement, search both tables, update the
   // location counter, start address, byte count and tables, and
   // load the result register.
   apsa_datapath #(
      .OPCODE_DEPTH (OPCODE_DEPTH),
      .SYMBOL_DEPTH (SYMBOL_DEPTH),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (dp_status),
      .req_operation          (req_operation),
      .req_label_present      (req_label_present),
      .req_label_text         (req_label_text),
      .req_mnemonic_text      (req_mnemonic_text),
      .req_operand_value      (req_operand_value),
      .req_operand_length     (req_operand_length),
      .req_operand_first_char (req_operand_first_char),
      .rsp_ready              (rsp_ready),
      .rsp_valid              (rsp_valid),
      .rsp_status             (rsp_status),
      .rsp_address            (rsp_address),
      .rsp_program_length     (rsp_program_length),
      .rsp_object_bytes       (rsp_object_bytes),
      .rsp_symbol_count       (rsp_symbol_count)
   );

`ifndef SYNTHESIS
   // A commit always leaves a result waiting
   a_commit_fills_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit did not produce a result");

   // One transaction at a time: an accept always leaves the idle state
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while previous transaction in flight");

   // A scan starts only together with an accept
   a_scan_with_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |-> (req_valid && req_ready))
      else $error("scan started without an accepted transaction");

   // A taken result without a new commit empties the result register
   a_result_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !cmd.commit) |=> !rsp_valid)
      else $error("result repeated after it was taken");
`endif

endmodule

// ===== sv/apsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module apsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/apsa_ctrl.sv =====
// Controller state machine: accept, table scan, commit.
module apsa_ctrl import apsa_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [OPERATION_BITS-1:0] req_operation,
   output logic                      req_ready,
   input  dp_status_type             status,
   output dp_cmd_type                cmd
);

   ctl_state_type state_ff, state_in;
   logic          needs_scan;

   // Only a live source statement needs the table scans
   assign needs_scan = (req_operation == OP_SOURCE) && !status.halted;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE: begin
            if (req_valid) begin
               state_in = needs_scan ? CTL_SCAN : CTL_COMMIT;
            end
         end
         CTL_SCAN: begin
            if (status.scan_done) begin
               state_in = CTL_COMMIT;
            end
         end
         CTL_COMMIT: begin
            if (status.out_free) begin
               state_in = CTL_IDLE;
            end
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      cmd.load_item  = 1'b0;
      cmd.scan_start = 1'b0;
      cmd.scan_run   = 1'b0;
      cmd.commit     = 1'b0;
      unique case (state_ff)
         CTL_IDLE: begin
            req_ready      = 1'b1;
            cmd.load_item  = req_valid;
            cmd.scan_start = req_valid && needs_scan;
         end
         CTL_SCAN: begin
            cmd.scan_run = 1'b1;
         end
         CTL_COMMIT: begin
            cmd.commit = status.out_free;
         end
         default: ;
      endcase
   end

endmodule

// ===== sv/apsa_datapath.sv =====
// Datapath: item registers, table RAMs, scan counter, counters and result register.
module apsa_datapath import apsa_pkg::*; #(
   parameter int OPCODE_DEPTH = OPCODE_DEPTH_DEFAULT,
   parameter int SYMBOL_DEPTH = SYMBOL_DEPTH_DEFAULT,
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   output dp_status_type             status,
   input  logic [OPERATION_BITS-1:0] req_operation,
   input  logic                      req_label_present,
   input  logic [TEXT_BITS-1:0]      req_label_text,
   input  logic [TEXT_BITS-1:0]      req_mnemonic_text,
   input  logic [VALUE_BITS-1:0]     req_operand_value,
   input  logic [LENGTH_BITS-1:0]    req_operand_length,
   input  logic [CHAR_BITS-1:0]      req_operand_first_char,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [STATUS_BITS-1:0]    rsp_status,
   output logic [OUT_ADDR_BITS-1:0]  rsp_address,
   output logic [OUT_ADDR_BITS-1:0]  rsp_program_length,
   output logic [OUT_ADDR_BITS-1:0]  rsp_object_bytes,
   output logic [COUNT_BITS-1:0]     rsp_symbol_count
);

   localparam int OP_AW     = $clog2(OPCODE_DEPTH);
   localparam int SYM_AW    = $clog2(SYMBOL_DEPTH);
   localparam int OP_CW     = $clog2(OPCODE_DEPTH + 1);
   localparam int SYM_CW    = $clog2(SYMBOL_DEPTH + 1);
   localparam int MAX_DEPTH = (OPCODE_DEPTH > SYMBOL_DEPTH) ? OPCODE_DEPTH : SYMBOL_DEPTH;
   localparam int SCAN_W    = $clog2(MAX_DEPTH + 1);

   localparam logic [OP_CW-1:0]        OP_FULL    = OP_CW'(OPCODE_DEPTH);
   localparam logic [SYM_CW-1:0]       SYM_FULL   = SYM_CW'(SYMBOL_DEPTH);
   localparam logic [ADDRESS_BITS-1:0] WORD_SIZE  = ADDRESS_BITS'(WORD_BYTES);

   // Latched item
   logic [OPERATION_BITS-1:0] op_ff;
   logic                      label_present_ff;
   logic [TEXT_BITS-1:0]      label_ff;
   logic [TEXT_BITS-1:0]      mnem_ff;
   logic [VALUE_BITS-1:0]     value_ff;
   logic [LENGTH_BITS-1:0]    olen_ff;
   logic [CHAR_BITS-1:0]      first_ff;

   // Assembler state
   logic [OP_CW-1:0]        op_count_ff;
   logic [SYM_CW-1:0]       sym_total_ff;
   logic [ADDRESS_BITS-1:0] lc_ff;
   logic [ADDRESS_BITS-1:0] start_ff;
   logic [ADDRESS_BITS-1:0] code_ff;
   logic                    halted_ff;

   // Scan state
   logic [SCAN_W-1:0] idx_ff, idx_in;
   logic              sym_iss_ff, op_iss_ff;
   logic              sym_hit_ff, op_hit_ff;
   logic [SCAN_W-1:0] sym_lim, op_lim;
   logic              sym_iss_now, op_iss_now;

   logic [TEXT_BITS-1:0] sym_rd_data, op_rd_data;

   // Result register
   logic                     rsp_valid_ff;
   logic [STATUS_BITS-1:0]   rsp_status_ff;
   logic [OUT_ADDR_BITS-1:0] rsp_address_ff;
   logic [OUT_ADDR_BITS-1:0] rsp_length_ff;
   logic [OUT_ADDR_BITS-1:0] rsp_bytes_ff;
   logic [COUNT_BITS-1:0]    rsp_count_ff;

   // Commit values
   logic [STATUS_BITS-1:0]  status_in;
   logic [ADDRESS_BITS-1:0] addr_in, lc_in, start_in, code_in;
   logic [ADDRESS_BITS-1:0] length_in;
   logic [OP_CW-1:0]        op_count_in;
   logic [SYM_CW-1:0]       sym_total_in;
   logic                    halted_in;
   logic                    op_we, sym_we;
   logic [ADDRESS_BITS-1:0] loc_add, code_add;
   logic [LENGTH_BITS-1:0]  byte_len;
   logic [VALUE_BITS+1:0]   resw_size;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff            <= req_operation;
         label_present_ff <= req_label_present;
         label_ff         <= req_label_text;
         mnem_ff          <= req_mnemonic_text;
         value_ff         <= req_operand_value;
         olen_ff          <= req_operand_length;
         first_ff         <= req_operand_first_char;
      end
   end

   // Scan both tables in lockstep; each issued read is compared in the cycle after its issue
   assign sym_lim     = label_present_ff ? SCAN_W'(sym_total_ff) : '0;
   assign op_lim      = SCAN_W'(op_count_ff);
   assign sym_iss_now = cmd.scan_run && (idx_ff < sym_lim);
   assign op_iss_now  = cmd.scan_run && (idx_ff < op_lim);
   assign idx_in      = idx_ff + SCAN_W'(sym_iss_now || op_iss_now);

   assign status.scan_done = cmd.scan_run && !sym_iss_now && !op_iss_now &&
                             !sym_iss_ff && !op_iss_ff;
   assign status.halted    = halted_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         sym_iss_ff <= 1'b0;
         op_iss_ff  <= 1'b0;
         sym_hit_ff <= 1'b0;
         op_hit_ff  <= 1'b0;
      end else if (cmd.scan_start) begin
         idx_ff     <= '0;
         sym_iss_ff <= 1'b0;
         op_iss_ff  <= 1'b0;
         sym_hit_ff <= 1'b0;
         op_hit_ff  <= 1'b0;
      end else begin
         idx_ff     <= idx_in;
         sym_iss_ff <= sym_iss_now;
         op_iss_ff  <= op_iss_now;
         if (sym_iss_ff && (sym_rd_data == label_ff)) begin
            sym_hit_ff <= 1'b1;
         end
         if (op_iss_ff && (op_rd_data == mnem_ff)) begin
            op_hit_ff <= 1'b1;
         end
      end
   end

   apsa_ram #(
      .WIDTH (TEXT_BITS),
      .DEPTH (OPCODE_DEPTH)
   ) u_opcode_ram (
      .clock   (clock),
      .wr_en   (op_we),
      .wr_addr (op_count_ff[OP_AW-1:0]),
      .wr_data (mnem_ff),
      .rd_addr (idx_ff[OP_AW-1:0]),
      .rd_data (op_rd_data)
   );

   apsa_ram #(
      .WIDTH (TEXT_BITS),
      .DEPTH (SYMBOL_DEPTH)
   ) u_symbol_ram (
      .clock   (clock),
      .wr_en   (sym_we),
      .wr_addr (sym_total_ff[SYM_AW-1:0]),
      .wr_data (label_ff),
      .rd_addr (idx_ff[SYM_AW-1:0]),
      .rd_data (sym_rd_data)
   );

   // Statement size
   always_comb begin
      byte_len = (olen_ff >= BYTE_OVERHEAD) ? (olen_ff - BYTE_OVERHEAD) : '0;
      if ((first_ff != CHAR_UPPER_C) && (first_ff != CHAR_LOWER_C)) begin
         byte_len = byte_len >> 1;
      end
      resw_size = {2'b00, value_ff} + {1'b0, value_ff, 1'b0};
      loc_add   = '0;
      code_add  = '0;
      if (op_hit_ff || (mnem_ff == TEXT_WORD)) begin
         loc_add  = WORD_SIZE;
         code_add = WORD_SIZE;
      end else if (mnem_ff == TEXT_RESW) begin
         loc_add = ADDRESS_BITS'(resw_size);
      end else if (mnem_ff == TEXT_RESB) begin
         loc_add = ADDRESS_BITS'(value_ff);
      end else if (mnem_ff == TEXT_BYTE) begin
         loc_add  = ADDRESS_BITS'(byte_len);
         code_add = ADDRESS_BITS'(byte_len);
      end
   end

   // Commit: state updates and result of the latched item
   always_comb begin
      status_in    = STATUS_OK;
      addr_in      = lc_ff;
      lc_in        = lc_ff;
      start_in     = start_ff;
      code_in      = code_ff;
      op_count_in  = op_count_ff;
      sym_total_in = sym_total_ff;
      halted_in    = halted_ff;
      op_we        = 1'b0;
      sym_we       = 1'b0;
      unique case (op_ff)
         OP_START: begin
            halted_in    = 1'b0;
            start_in     = ADDRESS_BITS'(value_ff);
            lc_in        = ADDRESS_BITS'(value_ff);
            addr_in      = ADDRESS_BITS'(value_ff);
            code_in      = '0;
            sym_total_in = '0;
         end
         OP_LOAD: begin
            if (halted_ff) begin
               status_in = STATUS_HALTED;
            end else if (op_count_ff != OP_FULL) begin
               op_we       = cmd.commit;
               op_count_in = op_count_ff + OP_CW'(1);
            end else begin
               status_in = STATUS_OP_FULL;
            end
         end
         OP_SOURCE: begin
            if (halted_ff) begin
               status_in = STATUS_HALTED;
            end else if (label_present_ff && sym_hit_ff) begin
               status_in = STATUS_DUP;
               halted_in = 1'b1;
            end else begin
               if (label_present_ff) begin
                  if (sym_total_ff != SYM_FULL) begin
                     sym_we       = cmd.commit;
                     sym_total_in = sym_total_ff + SYM_CW'(1);
                  end else begin
                     status_in = STATUS_SYM_FULL;
                  end
               end
               lc_in   = lc_ff + loc_add;
               code_in = code_ff + code_add;
            end
         end
         OP_END: begin
            if (halted_ff) begin
               status_in = STATUS_HALTED;
            end
         end
         default: ;
      endcase
   end

   // Program length wraps at the address width before it is widened
   assign length_in = lc_in - start_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_count_ff  <= '0;
         sym_total_ff <= '0;
         lc_ff        <= '0;
         start_ff     <= '0;
         code_ff      <= '0;
         halted_ff    <= 1'b0;
      end else if (cmd.commit) begin
         op_count_ff  <= op_count_in;
         sym_total_ff <= sym_total_in;
         lc_ff        <= lc_in;
         start_ff     <= start_in;
         code_ff      <= code_in;
         halted_ff    <= halted_in;
      end
   end

   // Result register: hold until taken, reload on the next commit
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff  <= status_in;
         rsp_address_ff <= OUT_ADDR_BITS'(addr_in);
         rsp_length_ff  <= OUT_ADDR_BITS'(length_in);
         rsp_bytes_ff   <= OUT_ADDR_BITS'(code_in);
         rsp_count_ff   <= COUNT_BITS'(sym_total_in);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_address        = rsp_address_ff;
   assign rsp_program_length = rsp_length_ff;
   assign rsp_object_bytes   = rsp_bytes_ff;
   assign rsp_symbol_count   = rsp_count_ff;

endmodule

// ===== verif/assembler_pass1_symbol_allocator_checker.sv =====
// Checker for the pass-one symbol allocator: predicts each statement's result and compares.
module assembler_pass1_symbol_allocator_checker import apsa_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [OPERATION_BITS-1:0] req_operation,
   input  logic                      req_label_present,
   input  logic [TEXT_BITS-1:0]      req_label_text,
   input  logic [TEXT_BITS-1:0]      req_mnemonic_text,
   input  logic [VALUE_BITS-1:0]     req_operand_value,
   input  logic [LENGTH_BITS-1:0]    req_operand_length,
   input  logic [CHAR_BITS-1:0]      req_operand_first_char,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [STATUS_BITS-1:0]    rsp_status,
   input  logic [OUT_ADDR_BITS-1:0]  rsp_address,
   input  logic [OUT_ADDR_BITS-1:0]  rsp_program_length,
   input  logic [OUT_ADDR_BITS-1:0]  rsp_object_bytes,
   input  logic [COUNT_BITS-1:0]     rsp_symbol_count,
   output int                        mismatch_count,
   output int                        outstanding
);

   localparam int ADDR_W = ADDRESS_BITS_DEFAULT;

   typedef struct packed {
      logic [STATUS_BITS-1:0]   status;
      logic [OUT_ADDR_BITS-1:0] address;
      logic [OUT_ADDR_BITS-1:0] program_length;
      logic [OUT_ADDR_BITS-1:0] object_bytes;
      logic [COUNT_BITS-1:0]    symbol_count;
   } alloc_result_type;

   // Assembler state as the block should hold it
   logic [TEXT_BITS-1:0] known_opcodes [OPCODE_DEPTH_DEFAULT];
   logic [TEXT_BITS-1:0] defined_labels [SYMBOL_DEPTH_DEFAULT];
   int                   opcodes_loaded;
   int                   labels_held;
   logic [ADDR_W-1:0]    loc_ctr;
   logic [ADDR_W-1:0]    prog_start;
   logic [ADDR_W-1:0]    code_count;
   logic                 stopped;

   alloc_result_type expected_results [$];
   alloc_result_type want;

   task automatic report_mismatch(input string note);
      $display("[%0t] allocator mismatch: %s", $time, note);
      mismatch_count++;
   endtask

   function automatic alloc_result_type allocate(
      input logic [OPERATION_BITS-1:0] op,
      input logic                      has_label,
      input logic [TEXT_BITS-1:0]      label,
      input logic [TEXT_BITS-1:0]      mnem,
      input logic [VALUE_BITS-1:0]     value,
      input logic [LENGTH_BITS-1:0]    olen,
      input logic [CHAR_BITS-1:0]      first
   );
      alloc_result_type        res;
      logic [ADDR_W-1:0]       loc_add;
      logic [ADDR_W-1:0]       code_add;
      logic [LENGTH_BITS-1:0]  byte_len;
      logic                    is_dup;
      logic                    is_opcode;
      int                      k;
      res.status  = STATUS_OK;
      res.address = loc_ctr;
      if (op == OP_START) begin
         stopped     = 1'b0;
         prog_start  = value;
         loc_ctr     = value;
         labels_held = 0;
         code_count  = '0;
         res.address = value;
      end else if (stopped) begin
         res.status = STATUS_HALTED;
      end else if (op == OP_LOAD) begin
         if (opcodes_loaded < OPCODE_DEPTH_DEFAULT) begin
            known_opcodes[opcodes_loaded] = mnem;
            opcodes_loaded++;
         end else begin
            res.status = STATUS_OP_FULL;
         end
      end else if (op == OP_SOURCE) begin
         is_dup = 1'b0;
         if (has_label) begin
            for (k = 0; k < labels_held; k++)
               if (defined_labels[k] == label) is_dup = 1'b1;
            if (is_dup) begin
               res.status = STATUS_DUP;
               stopped    = 1'b1;
            end else if (labels_held < SYMBOL_DEPTH_DEFAULT) begin
               defined_labels[labels_held] = label;
               labels_held++;
            end else begin
               res.status = STATUS_SYM_FULL;
            end
         end
         if (!is_dup) begin
            loc_add   = '0;
            code_add  = '0;
            is_opcode = 1'b0;
            for (k = 0; k < opcodes_loaded; k++)
               if (known_opcodes[k] == mnem) is_opcode = 1'b1;
            if (is_opcode || mnem == TEXT_WORD) begin
               loc_add  = WORD_BYTES;
               code_add = WORD_BYTES;
            end else if (mnem == TEXT_RESW) begin
               loc_add = ADDR_W'(value * WORD_BYTES);
            end else if (mnem == TEXT_RESB) begin
               loc_add = value;
            end else if (mnem == TEXT_BYTE) begin
               byte_len = '0;
               if (olen >= BYTE_OVERHEAD) begin
                  byte_len = olen - BYTE_OVERHEAD;
                  // hex literals pack two digits per byte
                  if (first != CHAR_UPPER_C && first != CHAR_LOWER_C)
                     byte_len = byte_len >> 1;
               end
               loc_add  = ADDR_W'(byte_len);
               code_add = loc_add;
            end
            loc_ctr    = loc_ctr + loc_add;
            code_count = code_count + code_add;
         end
      end
      res.program_length = OUT_ADDR_BITS'(loc_ctr - prog_start);
      res.object_bytes   = code_count;
      res.symbol_count   = COUNT_BITS'(labels_held);
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         opcodes_loaded = 0;
         labels_held    = 0;
         loc_ctr        = '0;
         prog_start     = '0;
         code_count     = '0;
         stopped        = 1'b0;
         expected_results.delete();
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(allocate(req_operation, req_label_present,
               req_label_text, req_mnemonic_text, req_operand_value,
               req_operand_length, req_operand_first_char));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected, address %h",
                  rsp_address));
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                     rsp_status, want.status));
               if (rsp_address !== want.address)
                  report_mismatch($sformatf("address got %h want %h",
                     rsp_address, want.address));
               if (rsp_program_length !== want.program_length)
                  report_mismatch($sformatf("program_length got %h want %h",
                     rsp_program_length, want.program_length));
               if (rsp_object_bytes !== want.object_bytes)
                  report_mismatch($sformatf("object_bytes got %h want %h",
                     rsp_object_bytes, want.object_bytes));
               if (rsp_symbol_count !== want.symbol_count)
                  report_mismatch($sformatf("symbol_count got %0d want %0d",
                     rsp_symbol_count, want.symbol_count));
            end
         end
      end
      outstanding = expected_results.size();
   end

endmodule

// ===== verif/assembler_pass1_symbol_allocator_tb.sv =====
// Testbench top for the pass-one symbol allocator: stimulus, handshake pacing and verdict.
module assembler_pass1_symbol_allocator_tb;
   import apsa_pkg::*;

   // Packed source text, first character in the low byte
   localparam logic [TEXT_BITS-1:0] TEXT_START  = 64'h0000_0054_5241_5453;
   localparam logic [TEXT_BITS-1:0] TEXT_END    = 64'h0000_0000_0044_4E45;
   localparam logic [TEXT_BITS-1:0] TEXT_LDA    = 64'h0000_0000_0041_444C;
   localparam logic [TEXT_BITS-1:0] TEXT_ONES   = {TEXT_BITS{1'b1}};
   localparam logic [TEXT_BITS-1:0] LABEL_ALPHA = 64'h0000_0041_4850_4C41;
   localparam logic [TEXT_BITS-1:0] LABEL_LOOP  = 64'h0000_0000_504F_4F4C;
   localparam logic [CHAR_BITS-1:0] CHAR_X      = 8'h58;

   localparam int RANDOM_ITEMS = 1300;
   // Run time limit for the watchdog, many times the slowest legal run
   localparam int RUN_LIMIT    = 8_000_000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [OPERATION_BITS-1:0] req_operation = OP_LOAD;
   logic                      req_label_present = 1'b0;
   logic [TEXT_BITS-1:0]      req_label_text = '0;
   logic [TEXT_BITS-1:0]      req_mnemonic_text = '0;
   logic [VALUE_BITS-1:0]     req_operand_value = '0;
   logic [LENGTH_BITS-1:0]    req_operand_length = '0;
   logic [CHAR_BITS-1:0]      req_operand_first_char = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [STATUS_BITS-1:0]    rsp_status;
   logic [OUT_ADDR_BITS-1:0]  rsp_address;
   logic [OUT_ADDR_BITS-1:0]  rsp_program_length;
   logic [OUT_ADDR_BITS-1:0]  rsp_object_bytes;
   logic [COUNT_BITS-1:0]     rsp_symbol_count;

   int mismatch_total;
   int results_pending;
   // Remaining items of a stretch with no idling, one per side
   int req_burst = 0;
   int rsp_burst = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   assembler_pass1_symbol_allocator u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_operation          (req_operation),
      .req_label_present      (req_label_present),
      .req_label_text         (req_label_text),
      .req_mnemonic_text      (req_mnemonic_text),
      .req_operand_value      (req_operand_value),
      .req_operand_length     (req_operand_length),
      .req_operand_first_char (req_operand_first_char),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_status             (rsp_status),
      .rsp_address            (rsp_address),
      .rsp_program_length     (rsp_program_length),
      .rsp_object_bytes       (rsp_object_bytes),
      .rsp_symbol_count       (rsp_symbol_count)
   );

   // Watches both channels, predicts every result and counts mismatches
   assembler_pass1_symbol_allocator_checker u_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_operation          (req_operation),
      .req_label_present      (req_label_present),
      .req_label_text         (req_label_text),
      .req_mnemonic_text      (req_mnemonic_text),
      .req_operand_value      (req_operand_value),
      .req_operand_length     (req_operand_length),
      .req_operand_first_char (req_operand_first_char),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_status             (rsp_status),
      .rsp_address            (rsp_address),
      .rsp_program_length     (rsp_program_length),
      .rsp_object_bytes       (rsp_object_bytes),
      .rsp_symbol_count       (rsp_symbol_count),
      .mismatch_count         (mismatch_total),
      .outstanding            (results_pending)
   );

   // Draw the idle cycles ahead of one transaction. Now and then start a
   // stretch where this side never idles; otherwise favor short waits but
   // reach the full range.
   function automatic int draw_wait(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         burst_left = $urandom_range(8, 40);
         return 0;
      end
      if ($urandom_range(0, 1) == 0)
         return $urandom_range(0, 3);
      return $urandom_range(0, 17);
   endfunction

   // Present one statement and hold it until accepted. Every call starts and
   // ends right after a rising edge. Valid is lowered only when a gap follows,
   // so it never gets two assignments in one time step.
   task automatic send_statement(
      input logic [OPERATION_BITS-1:0] op,
      input logic                      label_on,
      input logic [TEXT_BITS-1:0]      label,
      input logic [TEXT_BITS-1:0]      mnem,
      input logic [VALUE_BITS-1:0]     value,
      input logic [LENGTH_BITS-1:0]    olen,
      input logic [CHAR_BITS-1:0]      first
   );
      int gap;
      gap = draw_wait(req_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_operation          <= op;
      req_label_present      <= label_on;
      req_label_text         <= label;
      req_mnemonic_text      <= mnem;
      req_operand_value      <= value;
      req_operand_length     <= olen;
      req_operand_first_char <= first;
      // ready is sampled as it stood at the edge, before this edge's updates
      do @(posedge clock); while (!req_ready);
   endtask

   // Result side: stall a drawn number of cycles, then take the next result
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(rsp_burst);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      logic [TEXT_BITS-1:0]   loaded_names [$];
      logic [TEXT_BITS-1:0]   program_labels [$];
      logic [TEXT_BITS-1:0]   label;
      logic [TEXT_BITS-1:0]   mnem;
      logic [VALUE_BITS-1:0]  value;
      logic [VALUE_BITS-1:0]  start_at;
      logic [LENGTH_BITS-1:0] olen;
      logic [CHAR_BITS-1:0]   first;
      logic                   label_on;
      bit                     long_run;
      bit                     halted_now;
      bit                     dup_now;
      int                     items_sent;
      int                     stmt_total;
      int                     n;
      int                     pick;
      int                     idx;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- Directed part ----
      // A statement before any START runs from the reset counter
      send_statement(OP_SOURCE, 1'b0, '0, TEXT_WORD, '0, '0, '0);
      send_statement(OP_LOAD, 1'b0, '0, TEXT_LDA, '0, '0, '0);
      send_statement(OP_LOAD, 1'b0, '0, TEXT_ONES, '0, '0, '0);
      // Start near the top of the address space so the counter wraps
      send_statement(OP_START, 1'b0, '0, '0, 24'hFF_FFFD, '0, '0);
      send_statement(OP_SOURCE, 1'b1, LABEL_ALPHA, TEXT_LDA, '0, '0, '0);
      // All-ones fields everywhere, label text present but not flagged
      send_statement(OP_SOURCE, 1'b0, TEXT_ONES, TEXT_ONES, '1, '1, '1);
      send_statement(OP_SOURCE, 1'b1, TEXT_ONES, TEXT_WORD, '0, '0, '0);
      // Largest reservations wrap the counter, zero label is a real label
      send_statement(OP_SOURCE, 1'b1, '0, TEXT_RESW, '1, '0, '0);
      send_statement(OP_SOURCE, 1'b0, '0, TEXT_RESB, '1, '0, '0);
      // Byte literals: character, lower-case character, odd hex, too short, longest hex
      send_statement(OP_SOURCE, 1'b0, '0, TEXT_BYTE, '0, 5'd31, CHAR_UPPER_C);
      send_statement(OP_SOURCE, 1'b0, '0, TEXT_BYTE, '0, 5'd3, CHAR_LOWER_C);
      send_statement(OP_SOURCE, 1'b0, '0, TEXT_BYTE, '0, 5'd8, CHAR_X);
      send_statement(OP_SOURCE, 1'b0, '0, TEXT_BYTE, '0, 5'd2, CHAR_X);
      send_statement(OP_SOURCE, 1'b0, '0, TEXT_BYTE, '0, '1, '1);
      // START and END spelled as mnemonics are plain unknown statements
      send_statement(OP_SOURCE, 1'b0, '0, TEXT_START, '0, '0, '0);
      send_statement(OP_SOURCE, 1'b0, '0, TEXT_END, '0, '0, '0);
      send_statement(OP_END, 1'b0, '0, '0, '0, '0, '0);
      // Statements after END continue from the same counter
      send_statement(OP_SOURCE, 1'b1, LABEL_LOOP, TEXT_LDA, '0, '0, '0);
      // Duplicate label halts; everything but START is then refused
      send_statement(OP_SOURCE, 1'b1, LABEL_ALPHA, TEXT_WORD, '0, '0, '0);
      send_statement(OP_SOURCE, 1'b0, '0, TEXT_WORD, '0, '0, '0);
      send_statement(OP_LOAD, 1'b0, '0, TEXT_LDA, '0, '0, '0);
      send_statement(OP_END, 1'b0, '0, '0, '0, '0, '0);
      // START clears the halt and the symbol table, so the label is free again
      send_statement(OP_START, 1'b0, '0, '0, '0, '0, '0);
      send_statement(OP_SOURCE, 1'b1, LABEL_ALPHA, TEXT_RESB, '0, '0, '0);
      send_statement(OP_END, 1'b0, '0, '0, '0, '0, '0);

      // ---- Random part ----
      // Mostly whole programs: START, statements with labels, END. A few
      // long programs overflow the symbol table, table loads are sprinkled
      // in until the opcode table overflows too, and some programs carry a
      // duplicate label followed by a short halted tail. The rest is noise
      // and programs missing their START or END.
      loaded_names.push_back(TEXT_LDA);
      loaded_names.push_back(TEXT_ONES);
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 8) begin
            send_statement(OP_LOAD + OPERATION_BITS'($urandom_range(0, 3)), 1'($urandom),
               {$urandom, $urandom}, {$urandom, $urandom}, VALUE_BITS'($urandom),
               LENGTH_BITS'($urandom), CHAR_BITS'($urandom));
            items_sent++;
         end else begin
            long_run   = ($urandom_range(0, 9) == 0);
            stmt_total = long_run ? $urandom_range(33, 44) : $urandom_range(1, 20);
            halted_now = 1'b0;
            program_labels.delete();
            if ($urandom_range(0, 9) != 0) begin
               pick = $urandom_range(0, 9);
               if (pick < 6)
                  start_at = VALUE_BITS'($urandom_range(0, 'h7FFF));
               else if (pick < 8)
                  start_at = VALUE_BITS'($urandom);
               else
                  start_at = 24'hFF_FFFF - VALUE_BITS'($urandom_range(0, 64));
               send_statement(OP_START, 1'($urandom), {$urandom, $urandom},
                  {$urandom, $urandom}, start_at, LENGTH_BITS'($urandom),
                  CHAR_BITS'($urandom));
               items_sent++;
            end
            for (n = 0; n < stmt_total; n++) begin
               // halted items are only refused, so they do not count
               if (!halted_now) items_sent++;
               if ($urandom_range(0, 15) == 0) begin
                  if ($urandom_range(0, 1) == 0)
                     mnem = {$urandom, $urandom};
                  else
                     mnem = {40'd0, 8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                        8'($urandom_range(65, 90))};
                  loaded_names.push_back(mnem);
                  send_statement(OP_LOAD, 1'($urandom), {$urandom, $urandom}, mnem,
                     VALUE_BITS'($urandom), LENGTH_BITS'($urandom), CHAR_BITS'($urandom));
                  continue;
               end

               // Label: fresh, a near miss of one already defined, or a repeat
               label_on = long_run || ($urandom_range(0, 2) != 0);
               label    = {$urandom, $urandom};
               dup_now  = 1'b0;
               if (label_on && program_labels.size() > 0) begin
                  pick = $urandom_range(0, 99);
                  idx  = $urandom_range(0, program_labels.size() - 1);
                  if (pick < 2 && !long_run) begin
                     label   = program_labels[idx];
                     dup_now = 1'b1;
                  end else if (pick < 6) begin
                     label = program_labels[idx] ^ (64'd1 << $urandom_range(0, 63));
                  end
               end
               // only labels that made it into the table can be repeated
               if (label_on && !dup_now && program_labels.size() < SYMBOL_DEPTH_DEFAULT)
                  program_labels.push_back(label);

               value = VALUE_BITS'($urandom);
               olen  = LENGTH_BITS'($urandom);
               first = CHAR_BITS'($urandom);
               pick  = $urandom_range(0, 99);
               if (pick < 40 && loaded_names.size() > 0)
                  mnem = loaded_names[$urandom_range(0, loaded_names.size() - 1)];
               else if (pick < 50)
                  mnem = TEXT_WORD;
               else if (pick < 58)
                  mnem = TEXT_RESW;
               else if (pick < 66)
                  mnem = TEXT_RESB;
               else if (pick < 80)
                  mnem = TEXT_BYTE;
               else if (pick < 84)
                  mnem = ($urandom_range(0, 1) == 0) ? TEXT_START : TEXT_END;
               else if (pick < 90)
                  mnem = TEXT_BYTE ^ (64'd1 << $urandom_range(0, 63));
               else
                  mnem = {$urandom, $urandom};
               // keep most reservations small so programs stay readable
               if ((mnem == TEXT_RESW || mnem == TEXT_RESB) && $urandom_range(0, 4) != 0)
                  value = VALUE_BITS'($urandom_range(0, 99));
               if (mnem == TEXT_BYTE) begin
                  pick = $urandom_range(0, 3);
                  if (pick == 0)
                     first = CHAR_UPPER_C;
                  else if (pick == 1)
                     first = CHAR_LOWER_C;
                  else if (pick == 2)
                     first = CHAR_X;
               end
               send_statement(OP_SOURCE, label_on, label, mnem, value, olen, first);
               if (dup_now) begin
                  // cut the program short: a few refused items, then move on
                  halted_now = 1'b1;
                  if (n + 1 + 3 < stmt_total)
                     stmt_total = n + 1 + $urandom_range(0, 3);
               end
            end
            if ($urandom_range(0, 9) != 0) begin
               send_statement(OP_END, 1'($urandom), {$urandom, $urandom},
                  {$urandom, $urandom}, VALUE_BITS'($urandom), LENGTH_BITS'($urandom),
                  CHAR_BITS'($urandom));
               if (!halted_now) items_sent++;
            end
         end
      end
      req_valid <= 1'b0;

      // Drain: wait for every predicted result, then watch for strays
      do @(posedge clock); while (results_pending != 0);
      repeat (64) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog: a hung handshake or a lost result ends the run here
   initial begin
      #(RUN_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

endmodule
